// ===== sv/ulam_spiral_prime_pixel_macros.svh =====
// Assertion macros for the Ulam spiral prime pixel checker.
// Depends on nothing; included by the checker file.
`ifndef ULAM_SPIRAL_PRIME_PIXEL_MACROS_SVH
`define ULAM_SPIRAL_PRIME_PIXEL_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define USPP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("uspp check failed");

// Next-cycle implication, disabled during reset.
`define USPP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("uspp check failed");

`endif

// ===== sv/uspp_pkg.sv =====
// Shared types and constants for the Ulam spiral prime pixel block.
// Depends on nothing; used by the top level and its checker.
`timescale 1ns / 1ps

package uspp_pkg;

   localparam int ROW_W       = 10;
   localparam int LEVEL_W     = 8;
   localparam int NUMBER_W    = 21;
   localparam int SIDE_DEFAULT = 1024;
   localparam logic [LEVEL_W-1:0] WHITE_LEVEL = 8'd255;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [ROW_W-1:0] column;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]  pixel_level;
      logic                is_prime;
      logic [NUMBER_W-1:0] spiral_number;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CENTER,
      ST_SQUARE,
      ST_TEST,
      ST_DIV,
      ST_FINISH
   } state_type;

endpackage

// ===== sv/ulam_spiral_prime_pixel.sv =====
// Ulam spiral prime pixel: spiral number of a pixel and its trial-division primality.
// Depends on uspp_pkg for the request/response types, constants and state codes.
`timescale 1ns / 1ps

//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  req     | in        | req_valid / req_stall  | req_data: row, column
//  rsp     | out       | rsp_valid / rsp_stall  | rsp_data: pixel_level, is_prime, number
//  csr     | in        | csr_valid / csr_ready  | csr_data: background level
//
//  Per request: centre, square, then for each trial divisor p = 2, 3, ... with p^2 <= n
//  the restoring remainder loop, one bit per cycle over the NW-bit number, until p divides
//  n or p^2 exceeds n; NW = 2*AW+1 is the spiral number width (23 at SIDE = 1024).
//  Requests stall until finish. Finish waits while a response stalls.
//  Reset is synchronous, active high: it clears the sequencer, response valid and level.
//  A stalled response holds in its register while the block takes the next request.

module ulam_spiral_prime_pixel #(
   parameter int SIDE = uspp_pkg::SIDE_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  uspp_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output uspp_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [uspp_pkg::LEVEL_W-1:0]       csr_data
);

   // Coordinate width: wide enough for the 10-bit index and for the centre offsets.
   localparam int SIDE_W = $clog2(SIDE);
   localparam int IDX_W  = (SIDE_W > uspp_pkg::ROW_W) ? SIDE_W : uspp_pkg::ROW_W;
   localparam int AW     = IDX_W + 1;     // signed x, y; unsigned ring size l
   localparam int DW     = AW + 3;        // signed offset d along the ring
   localparam int NW     = 2 * AW + 1;    // spiral number
   localparam int PW     = AW + 1;        // trial divisor
   localparam int SW     = NW + 1;        // divisor squared
   localparam int BW     = $clog2(NW);    // bit index into the spiral number

   localparam logic signed [AW-1:0] OFF_X = AW'((SIDE - 1) / 2);
   localparam logic signed [AW-1:0] OFF_Y = AW'(SIDE / 2);

   uspp_pkg::state_type state_ff, state_in;

   uspp_pkg::req_type            req_ff, req_in;
   uspp_pkg::rsp_type            rsp_ff, rsp_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [uspp_pkg::LEVEL_W-1:0] background_ff, background_in;
   logic [AW-1:0]                l_ff, l_in;
   logic [DW-2:0]                d_ff, d_in;
   logic [NW-1:0]                n_ff, n_in;
   logic [PW-1:0]                p_ff, p_in;
   logic [SW-1:0]                sq_ff, sq_in;
   logic [PW-1:0]                rem_ff, rem_in;
   logic [BW-1:0]                bit_ff, bit_in;
   logic                         prime_ff, prime_in;

   // Centering and ring geometry.
   logic signed [AW-1:0] x_s, y_s;
   logic [AW-1:0]        ax_u, ay_u, m_u, l_u;
   logic signed [DW-1:0] l_s, xe_s, ye_s, d_s;
   // Square of (l - 1).
   logic [AW-1:0]        lm_u;
   logic [2*AW-1:0]      lsq_u;
   // Shared restoring remainder step.
   logic [PW:0]          rem_sh, rem_sub;
   logic [PW-1:0]        rem_nx;

   always_comb begin
      x_s  = signed'(AW'(req_ff.row)) - OFF_X;
      y_s  = signed'(AW'(req_ff.column)) - OFF_Y;
      ax_u = x_s[AW-1] ? unsigned'(-x_s) : unsigned'(x_s);
      ay_u = y_s[AW-1] ? unsigned'(-y_s) : unsigned'(y_s);
      m_u  = (ax_u > ay_u) ? ax_u : ay_u;
      l_u  = {m_u[AW-2:0], 1'b0};
      l_s  = signed'(DW'(l_u));
      xe_s = DW'(x_s);
      ye_s = DW'(y_s);
      // d = 3l + x + y above the diagonal, l - x - y below it; never negative.
      if (y_s >= x_s) begin
         d_s = (l_s <<< 1) + l_s + xe_s + ye_s;
      end else begin
         d_s = l_s - xe_s - ye_s;
      end

      // (l - 1)^2 with l = 0 at the centre giving 1.
      lm_u  = (l_ff == '0) ? AW'(1) : l_ff - AW'(1);
      lsq_u = lm_u * lm_u;

      // Shift in the next dividend bit, subtract the divisor when it fits.
      rem_sh  = {rem_ff, n_ff[bit_ff]};
      rem_sub = rem_sh - {1'b0, p_ff};
      rem_nx  = (rem_sh >= {1'b0, p_ff}) ? rem_sub[PW-1:0] : rem_sh[PW-1:0];
   end

   // Sequencer: next state plus every datapath next value.
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      background_in = background_ff;
      l_in          = l_ff;
      d_in          = d_ff;
      n_in          = n_ff;
      p_in          = p_ff;
      sq_in         = sq_ff;
      rem_in        = rem_ff;
      bit_in        = bit_ff;
      prime_in      = prime_ff;

      // Drop the response once it is taken.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         background_in = csr_data;
      end

      unique case (state_ff)
         uspp_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = uspp_pkg::ST_CENTER;
            end
         end
         uspp_pkg::ST_CENTER: begin
            l_in     = l_u;
            d_in     = d_s[DW-2:0];
            state_in = uspp_pkg::ST_SQUARE;
         end
         uspp_pkg::ST_SQUARE: begin
            n_in     = NW'(lsq_u) + NW'(d_ff);
            p_in     = PW'(2);
            sq_in    = SW'(4);
            state_in = uspp_pkg::ST_TEST;
         end
         uspp_pkg::ST_TEST: begin
            // 0 and 1 are not prime; no divisor up to the root means prime.
            if (n_ff < NW'(2)) begin
               prime_in = 1'b0;
               state_in = uspp_pkg::ST_FINISH;
            end else if (sq_ff > {1'b0, n_ff}) begin
               prime_in = 1'b1;
               state_in = uspp_pkg::ST_FINISH;
            end else begin
               rem_in   = '0;
               bit_in   = BW'(NW - 1);
               state_in = uspp_pkg::ST_DIV;
            end
         end
         uspp_pkg::ST_DIV: begin
            rem_in = rem_nx;
            if (bit_ff == '0) begin
               if (rem_nx == '0) begin
                  prime_in = 1'b0;
                  state_in = uspp_pkg::ST_FINISH;
               end else begin
                  // Advance to p + 1; (p + 1)^2 = p^2 + 2p + 1.
                  p_in     = p_ff + PW'(1);
                  sq_in    = sq_ff + SW'({p_ff, 1'b1});
                  state_in = uspp_pkg::ST_TEST;
               end
            end else begin
               bit_in = bit_ff - BW'(1);
            end
         end
         uspp_pkg::ST_FINISH: begin
            // Hold until the output register is free or being emptied.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.pixel_level   = prime_ff ? uspp_pkg::WHITE_LEVEL : background_ff;
               rsp_in.is_prime      = prime_ff;
               rsp_in.spiral_number = n_ff[uspp_pkg::NUMBER_W-1:0];
               rsp_valid_in         = 1'b1;
               state_in             = uspp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = uspp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= uspp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         background_ff <= '0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         background_ff <= background_in;
      end
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      l_ff     <= l_in;
      d_ff     <= d_in;
      n_ff     <= n_in;
      p_ff     <= p_in;
      sq_ff    <= sq_in;
      rem_ff   <= rem_in;
      bit_ff   <= bit_in;
      prime_ff <= prime_in;
   end

   assign req_stall = (state_ff != uspp_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

// ===== sv/uspp_checker.sv =====
// Port-level checks for the Ulam spiral prime pixel block, bound to its top level.
// Depends on uspp_pkg and ulam_spiral_prime_pixel_macros.svh.
`timescale 1ns / 1ps
`include "ulam_spiral_prime_pixel_macros.svh"

module uspp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input uspp_pkg::req_type             req_data,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input uspp_pkg::rsp_type             rsp_data,
   input logic                          csr_valid,
   input logic                          csr_ready,
   input logic [uspp_pkg::LEVEL_W-1:0]  csr_data
);

   logic white_shown;
   logic req_waiting;
   logic rsp_waiting;

   assign white_shown = (rsp_data.pixel_level == uspp_pkg::WHITE_LEVEL);
   assign req_waiting = req_valid && req_stall;
   assign rsp_waiting = rsp_valid && rsp_stall;

   // A prime pixel is always white.
   `USPP_ASSERT_NOW(a_prime_white, clock, reset, rsp_valid && rsp_data.is_prime, white_shown)

   // An accepted request keeps the block busy in the next cycle.
   `USPP_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)

   // A stalled request holds.
   `USPP_ASSERT_NEXT(a_req_hold, clock, reset, req_waiting, req_valid && $stable(req_data))

   // A stalled response holds.
   `USPP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_waiting, rsp_valid && $stable(rsp_data))

   // The level register always takes a write.
   `USPP_ASSERT_NOW(a_csr_ready, clock, reset, csr_valid, csr_ready && !$isunknown(csr_data))

endmodule

bind ulam_spiral_prime_pixel uspp_checker u_uspp_checker (.*);

// ===== test/ulam_spiral_prime_pixel_tb.sv =====
// Self-checking bench for the Ulam spiral prime pixel block: directed corner pixels,
// then phases of random pixels under several background levels. Depends on uspp_pkg.
`timescale 1ns / 1ps

module ulam_spiral_prime_pixel_tb;

   localparam int ROW_W       = uspp_pkg::ROW_W;
   localparam int LEVEL_W     = uspp_pkg::LEVEL_W;
   localparam int NUMBER_W    = uspp_pkg::NUMBER_W;
   localparam logic [LEVEL_W-1:0] WHITE_LEVEL = uspp_pkg::WHITE_LEVEL;
   localparam int SIDE        = uspp_pkg::SIDE_DEFAULT;
   localparam int X_CENTER    = (SIDE - 1) / 2;
   localparam int Y_CENTER    = SIDE / 2;
   localparam int COORD_MAX   = (1 << ROW_W) - 1;
   localparam int HALF_PERIOD = 5;
   localparam int RESET_CYCLES = 3;
   localparam int TAIL_CYCLES = 64;
   localparam int NUM_PHASES  = 5;
   localparam int PHASE_ITEMS = 16;
   localparam int NUM_DIRECTED = 18;

   // One directed pixel; typed rows carry an expectation that is obvious by hand.
   typedef struct packed {
      logic [ROW_W-1:0]    row;
      logic [ROW_W-1:0]    column;
      bit                  typed;
      logic [LEVEL_W-1:0]  level;
      bit                  prime;
      logic [NUMBER_W-1:0] number;
   } pixel_case_type;

   logic     clock     = 1'b0;
   logic     reset     = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   uspp_pkg::req_type  req_data  = '0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   uspp_pkg::rsp_type  rsp_data;
   logic     csr_valid = 1'b0;
   logic     csr_ready;
   logic [LEVEL_W-1:0] csr_data = '0;

   logic [LEVEL_W-1:0] background_shadow = '0;   // background level as the block holds it
   uspp_pkg::rsp_type  expected_pixels[$];        // predicted pixels, oldest first
   int       mismatches = 0;
   bit       quiet      = 1'b0;                   // no idling on either side once set
   int       stall_left = 0;

   // Centre pixel, the first small numbers (2 and 3 prime, 4 and 9 not), then
   // the image corners and edges, and alternating bit patterns.
   pixel_case_type directed_cases [0:NUM_DIRECTED-1] = '{
      '{10'd511,  10'd512,  1'b1, 8'd0,        1'b0, 21'd1},
      '{10'd512,  10'd512,  1'b1, WHITE_LEVEL, 1'b1, 21'd2},
      '{10'd512,  10'd511,  1'b1, WHITE_LEVEL, 1'b1, 21'd3},
      '{10'd511,  10'd511,  1'b1, 8'd0,        1'b0, 21'd4},
      '{10'd510,  10'd511,  1'b1, WHITE_LEVEL, 1'b1, 21'd5},
      '{10'd512,  10'd513,  1'b1, 8'd0,        1'b0, 21'd9},
      '{10'd0,    10'd0,    1'b1, 8'd0,        1'b0, 21'd1048576},
      '{10'd0,    10'd1023, 1'b0, 8'd0,        1'b0, 21'd0},
      '{10'd1023, 10'd0,    1'b0, 8'd0,        1'b0, 21'd0},
      '{10'd1023, 10'd1023, 1'b0, 8'd0,        1'b0, 21'd0},
      '{10'd1023, 10'd512,  1'b0, 8'd0,        1'b0, 21'd0},
      '{10'd0,    10'd512,  1'b0, 8'd0,        1'b0, 21'd0},
      '{10'd511,  10'd0,    1'b0, 8'd0,        1'b0, 21'd0},
      '{10'd511,  10'd1023, 1'b0, 8'd0,        1'b0, 21'd0},
      '{10'd341,  10'd682,  1'b0, 8'd0,        1'b0, 21'd0},
      '{10'd682,  10'd341,  1'b0, 8'd0,        1'b0, 21'd0},
      '{10'd1022, 10'd1,    1'b0, 8'd0,        1'b0, 21'd0},
      '{10'd1,    10'd1022, 1'b0, 8'd0,        1'b0, 21'd0}
   };

   ulam_spiral_prime_pixel #(
      .SIDE(SIDE)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Hard stop: several times the slowest legal run (every pixel a prime near
   // the largest ring, plus all idling).
   initial begin
      #150_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   // Spiral number of a pixel: centre it, take the ring size from the larger
   // offset, then add the distance along the ring.
   function automatic longint spiral_of(input logic [ROW_W-1:0] row,
                                        input logic [ROW_W-1:0] column);
      longint x, y, ax, ay, ring, along;
      x = longint'(row);
      y = longint'(column);
      x = x - X_CENTER;
      y = y - Y_CENTER;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      ring = 2 * ((ax > ay) ? ax : ay);
      along = (y >= x) ? (3 * ring + x + y) : (ring - x - y);
      return (ring - 1) * (ring - 1) + along;
   endfunction

   // Trial division; 0 and 1 are not prime, 2 is.
   function automatic bit is_spiral_prime(input longint n);
      longint p;
      if (n < 2) return 1'b0;
      for (p = 2; p * p <= n; p++)
         if (n % p == 0) return 1'b0;
      return 1'b1;
   endfunction

   function automatic uspp_pkg::rsp_type predict_pixel(input uspp_pkg::req_type px);
      uspp_pkg::rsp_type res;
      longint  n;
      n = spiral_of(px.row, px.column);
      res.is_prime      = is_spiral_prime(n);
      res.pixel_level   = res.is_prime ? WHITE_LEVEL : background_shadow;
      res.spiral_number = n[NUMBER_W-1:0];
      return res;
   endfunction

   // Mostly pixels near the centre (short divisor loops), some on middle rings,
   // and a share anywhere in the image so every coordinate bit toggles.
   function automatic uspp_pkg::req_type random_pixel();
      uspp_pkg::req_type px;
      int unsigned pick;
      int          reach;
      pick = $urandom_range(0, 9);
      if (pick < 6)      reach = $urandom_range(1, 24);
      else if (pick < 7) reach = $urandom_range(25, 200);
      else               reach = 0;
      if (reach == 0) begin
         px.row    = ROW_W'($urandom_range(0, COORD_MAX));
         px.column = ROW_W'($urandom_range(0, COORD_MAX));
      end else begin
         px.row    = ROW_W'(X_CENTER + int'($urandom_range(0, 2 * reach)) - reach);
         px.column = ROW_W'(Y_CENTER + int'($urandom_range(0, 2 * reach)) - reach);
      end
      return px;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic note_pixel_error(input string what);
      $display("%0t ns mismatch: %s", $time, what);
      mismatches++;
   endtask

   // Compare each accepted pixel with the oldest prediction.
   always @(posedge clock) begin : check_pixels
      uspp_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            note_pixel_error("pixel delivered with no request outstanding");
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_data.spiral_number !== want.spiral_number)
               note_pixel_error($sformatf("spiral_number %0d, want %0d",
                                          rsp_data.spiral_number, want.spiral_number));
            if (rsp_data.is_prime !== want.is_prime)
               note_pixel_error($sformatf("is_prime %b, want %b (number %0d)",
                                          rsp_data.is_prime, want.is_prime,
                                          want.spiral_number));
            if (rsp_data.pixel_level !== want.pixel_level)
               note_pixel_error($sformatf("pixel_level %0d, want %0d (number %0d)",
                                          rsp_data.pixel_level, want.pixel_level,
                                          want.spiral_number));
         end
      end
   end

   // ---------------------------------------------------------------- idling

   // Stall the response side in random bursts; drop stall when quiet.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 9) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Hold the request side idle for a random burst now and then.
   task automatic sender_gap();
      int n;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 9);
         @(negedge clock) req_valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // ---------------------------------------------------------------- drivers

   // Offer one pixel and hold it until taken; queue its prediction on acceptance.
   task automatic send_pixel(input uspp_pkg::req_type px, input uspp_pkg::rsp_type want);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (req_stall);
      expected_pixels.push_back(want);
   endtask

   // Wait until every predicted pixel has come back.
   task automatic wait_for_drain();
      do @(negedge clock); while (expected_pixels.size() != 0);
   endtask

   // Write the background level; only called while the block is idle.
   task automatic write_background(input logic [LEVEL_W-1:0] level);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= level;
      do @(posedge clock); while (!csr_ready);
      background_shadow = level;
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin : run_pixels
      uspp_pkg::req_type  px;
      uspp_pkg::rsp_type  want;
      logic [LEVEL_W-1:0] level;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed pixels under the reset background level.
      foreach (directed_cases[i]) begin
         px.row    = directed_cases[i].row;
         px.column = directed_cases[i].column;
         if (directed_cases[i].typed) begin
            want.pixel_level   = directed_cases[i].level;
            want.is_prime      = directed_cases[i].prime;
            want.spiral_number = directed_cases[i].number;
         end else begin
            want = predict_pixel(px);
         end
         sender_gap();
         send_pixel(px, want);
      end
      @(negedge clock) req_valid <= 1'b0;

      // Random phases, each with its own background level: full white first,
      // then black, then random levels. The last phase runs without idling.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_for_drain();
         if (phase == 0)      level = WHITE_LEVEL;
         else if (phase == 1) level = '0;
         else                 level = LEVEL_W'($urandom_range(1, WHITE_LEVEL - 1));
         write_background(level);
         if (phase == NUM_PHASES - 1) quiet = 1'b1;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            px = random_pixel();
            sender_gap();
            send_pixel(px, predict_pixel(px));
         end
         @(negedge clock) req_valid <= 1'b0;
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/uspp_pkg.sv
sv/ulam_spiral_prime_pixel.sv
sv/uspp_checker.sv
test/ulam_spiral_prime_pixel_tb.sv
